/* sv/jsu_pkg.sv */
// shared types and constants of the json string unescaper
package jsu_pkg;

	typedef enum logic [2:0] {
		PH_WAIT,
		PH_STR,
		PH_ESC,
		PH_HEX,
		PH_LOW_BS,
		PH_LOW_U,
		PH_LOW_HEX
	} phase_t;

	typedef enum logic [1:0] {
		OP_RAW,
		OP_CP,
		OP_DONE,
		OP_ERR
	} cmd_op_t;

	typedef enum logic [3:0] {
		ERR_NONE          = 4'd0,
		ERR_NO_QUOTE      = 4'd1,
		ERR_UNTERM_ESC    = 4'd2,
		ERR_TRUNC_UNI     = 4'd3,
		ERR_BAD_HEX       = 4'd4,
		ERR_MISSING_LOW   = 4'd5,
		ERR_TRUNC_LOW     = 4'd6,
		ERR_BAD_LOW_HEX   = 4'd7,
		ERR_LOW_RANGE     = 4'd8,
		ERR_STRAY_LOW     = 4'd9,
		ERR_BAD_ESC       = 4'd10,
		ERR_CTRL_CHAR     = 4'd11,
		ERR_UNTERM_STR    = 4'd12
	} err_code_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} res_kind_t;

	localparam int CP_W = 21;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [5:0] HI_SURR_TAG = 6'b110110;
	localparam logic [5:0] LO_SURR_TAG = 6'b110111;
	localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

	typedef struct packed {
		cmd_op_t         op;
		logic [CP_W-1:0] cp;
		err_code_t       code;
	} cmd_t;

endpackage

/* sv/json_string_unescape_utf8.sv */
// top level of the json string unescaper
// Decodes the bytes of a JSON quoted string, one text byte per beat, into
// UTF-8 result beats. A text byte is taken every cycle while the command
// queue (QUEUE_DEPTH entries) has room; the decoder state machine handles it
// in that cycle. The back end drains the queue and sends one result beat per
// cycle while res_stall is low: one for a plain byte, simple escape, string end
// or error, and one to four for a \u escape or surrogate pair, so throughput is
// bounded by the single result port at one beat per cycle. Results pass the
// queue and the back end's command register. Every error ends the string with
// an error beat carrying its code; decoding resumes at the next opening quote.
module json_string_unescape_utf8 import jsu_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	output logic [3:0] fault_code,
	output logic       last
);

	logic accept;
	logic push;
	cmd_t push_cmd;
	logic pop;
	cmd_t head_cmd;
	logic q_full;
	logic q_empty;

	assign text_stall = q_full;
	assign accept     = text_valid && !q_full;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.text_byte (text_byte),
		.push      (push),
		.cmd       (push_cmd)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_cmd      (head_cmd),
		.q_pop      (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_byte   (out_byte),
		.kind       (kind),
		.fault_code (fault_code),
		.last       (last)
	);

endmodule

/* sv/jsu_front.sv */
// front end: escape decoding state machine, one text byte per cycle while accept is high
module jsu_front import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] text_byte,
	output logic       push,
	output cmd_t       cmd
);

	phase_t      phase_q, phase_d;
	logic [15:0] hex_q, hex_d;
	logic [9:0]  hs_q, hs_d;
	logic [1:0]  cnt_q, cnt_d;
	logic        bad_q, bad_d;

	logic [3:0]  nib;
	logic        nib_ok;
	logic [15:0] new_hex;
	logic        bad_n;
	logic        fourth;
	logic        is_hi;
	logic        is_lo;
	logic [CP_W-1:0] pair_cp;

	always_comb begin
		nib    = 4'd0;
		nib_ok = 1'b1;
		if (text_byte >= 8'h30 && text_byte <= 8'h39) begin
			nib = 4'(text_byte - 8'h30);
		end else if (text_byte >= 8'h61 && text_byte <= 8'h66) begin
			nib = 4'(text_byte - 8'h57);
		end else if (text_byte >= 8'h41 && text_byte <= 8'h46) begin
			nib = 4'(text_byte - 8'h37);
		end else begin
			nib_ok = 1'b0;
		end
	end

	assign new_hex = {hex_q[11:0], nib};
	assign bad_n   = bad_q | ~nib_ok;
	assign fourth  = (cnt_q == 2'd3);
	assign is_hi   = (new_hex[15:10] == HI_SURR_TAG);
	assign is_lo   = (new_hex[15:10] == LO_SURR_TAG);
	assign pair_cp = SUPP_BASE + {1'b0, hs_q, new_hex[9:0]};

	// next state
	always_comb begin
		phase_d = phase_q;
		hex_d   = hex_q;
		hs_d    = hs_q;
		cnt_d   = cnt_q;
		bad_d   = bad_q;
		case (phase_q)
			PH_WAIT: begin
				if (text_byte == CH_QUOTE) phase_d = PH_STR;
			end
			PH_STR: begin
				if (text_byte == CH_NUL || text_byte == CH_QUOTE) begin
					phase_d = PH_WAIT;
				end else if (text_byte == CH_BSL) begin
					phase_d = PH_ESC;
				end else if (text_byte < CH_SPACE) begin
					phase_d = PH_WAIT;
				end
			end
			PH_ESC: begin
				case (text_byte)
					CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T: begin
						phase_d = PH_STR;
					end
					CH_U: begin
						phase_d = PH_HEX;
						hex_d   = 16'd0;
						cnt_d   = 2'd0;
						bad_d   = 1'b0;
					end
					default: phase_d = PH_WAIT;
				endcase
			end
			PH_HEX, PH_LOW_HEX: begin
				if (text_byte == CH_NUL) begin
					phase_d = PH_WAIT;
				end else begin
					hex_d = new_hex;
					bad_d = bad_n;
					if (fourth) begin
						cnt_d = 2'd0;
						if (bad_n) begin
							phase_d = PH_WAIT;
						end else if (phase_q == PH_HEX) begin
							if (is_hi) begin
								hs_d    = new_hex[9:0];
								phase_d = PH_LOW_BS;
							end else if (is_lo) begin
								phase_d = PH_WAIT;
							end else begin
								phase_d = PH_STR;
							end
						end else begin
							phase_d = is_lo ? PH_STR : PH_WAIT;
						end
					end else begin
						cnt_d = cnt_q + 2'd1;
					end
				end
			end
			PH_LOW_BS: begin
				phase_d = (text_byte == CH_BSL) ? PH_LOW_U : PH_WAIT;
			end
			PH_LOW_U: begin
				if (text_byte == CH_U) begin
					phase_d = PH_LOW_HEX;
					hex_d   = 16'd0;
					cnt_d   = 2'd0;
					bad_d   = 1'b0;
				end else begin
					phase_d = PH_WAIT;
				end
			end
			default: phase_d = PH_WAIT;
		endcase
	end

	// commands to the back end
	always_comb begin
		push     = 1'b0;
		cmd.op   = OP_RAW;
		cmd.cp   = {13'd0, text_byte};
		cmd.code = ERR_NONE;
		case (phase_q)
			PH_WAIT: begin
				if (text_byte != CH_QUOTE) begin
					push     = 1'b1;
					cmd.op   = OP_ERR;
					cmd.code = ERR_NO_QUOTE;
				end
			end
			PH_STR: begin
				if (text_byte == CH_NUL) begin
					push     = 1'b1;
					cmd.op   = OP_ERR;
					cmd.code = ERR_UNTERM_STR;
				end else if (text_byte == CH_QUOTE) begin
					push   = 1'b1;
					cmd.op = OP_DONE;
				end else if (text_byte == CH_BSL) begin
					push = 1'b0;
				end else if (text_byte < CH_SPACE) begin
					push     = 1'b1;
					cmd.op   = OP_ERR;
					cmd.code = ERR_CTRL_CHAR;
				end else begin
					push = 1'b1;
				end
			end
			PH_ESC: begin
				push = 1'b1;
				case (text_byte)
					CH_QUOTE, CH_BSL, CH_SLASH: cmd.cp = {13'd0, text_byte};
					CH_B: cmd.cp = 21'h08;
					CH_F: cmd.cp = 21'h0C;
					CH_N: cmd.cp = 21'h0A;
					CH_R: cmd.cp = 21'h0D;
					CH_T: cmd.cp = 21'h09;
					CH_U: push = 1'b0;
					CH_NUL: begin
						cmd.op   = OP_ERR;
						cmd.code = ERR_UNTERM_ESC;
					end
					default: begin
						cmd.op   = OP_ERR;
						cmd.code = ERR_BAD_ESC;
					end
				endcase
			end
			PH_HEX: begin
				if (text_byte == CH_NUL) begin
					push     = 1'b1;
					cmd.op   = OP_ERR;
					cmd.code = ERR_TRUNC_UNI;
				end else if (fourth) begin
					if (bad_n) begin
						push     = 1'b1;
						cmd.op   = OP_ERR;
						cmd.code = ERR_BAD_HEX;
					end else if (is_lo) begin
						push     = 1'b1;
						cmd.op   = OP_ERR;
						cmd.code = ERR_STRAY_LOW;
					end else if (!is_hi) begin
						push   = 1'b1;
						cmd.op = OP_CP;
						cmd.cp = {5'd0, new_hex};
					end
				end
			end
			PH_LOW_BS: begin
				if (text_byte != CH_BSL) begin
					push     = 1'b1;
					cmd.op   = OP_ERR;
					cmd.code = ERR_MISSING_LOW;
				end
			end
			PH_LOW_U: begin
				if (text_byte != CH_U) begin
					push     = 1'b1;
					cmd.op   = OP_ERR;
					cmd.code = ERR_MISSING_LOW;
				end
			end
			PH_LOW_HEX: begin
				if (text_byte == CH_NUL) begin
					push     = 1'b1;
					cmd.op   = OP_ERR;
					cmd.code = ERR_TRUNC_LOW;
				end else if (fourth) begin
					push = 1'b1;
					if (bad_n) begin
						cmd.op   = OP_ERR;
						cmd.code = ERR_BAD_LOW_HEX;
					end else if (!is_lo) begin
						cmd.op   = OP_ERR;
						cmd.code = ERR_LOW_RANGE;
					end else begin
						cmd.op = OP_CP;
						cmd.cp = pair_cp;
					end
				end
			end
			default: begin
				push     = 1'b1;
				cmd.op   = OP_ERR;
				cmd.code = ERR_NO_QUOTE;
			end
		endcase
		if (!accept) push = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			hex_q   <= 16'd0;
			hs_q    <= 10'd0;
			cnt_q   <= 2'd0;
			bad_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			hex_q   <= hex_d;
			hs_q    <= hs_d;
			cnt_q   <= cnt_d;
			bad_q   <= bad_d;
		end
	end

endmodule

/* sv/jsu_queue.sv */
// command queue between the front and back ends
module jsu_queue import jsu_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head_cmd,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* sv/jsu_back.sv */
// back end: expands commands into result beats, utf-8 encoding code points
module jsu_back import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cmd_t       q_cmd,
	output logic       q_pop,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	output logic [3:0] fault_code,
	output logic       last
);

	cmd_t       cur_q;
	logic       cur_vld_q;
	logic [1:0] idx_q;
	logic [1:0] lidx;
	logic       beat_done;
	logic       cmd_done;
	logic [CP_W-1:0] cp;

	assign cp = cur_q.cp;

	always_comb begin
		lidx = 2'd0;
		if (cur_q.op == OP_CP) begin
			if (cp <= 21'h7F) lidx = 2'd0;
			else if (cp <= 21'h7FF) lidx = 2'd1;
			else if (cp <= 21'hFFFF) lidx = 2'd2;
			else lidx = 2'd3;
		end
	end

	always_comb begin
		out_byte = 8'h00;
		case (cur_q.op)
			OP_RAW: out_byte = cp[7:0];
			OP_CP: begin
				case (lidx)
					2'd0: out_byte = cp[7:0];
					2'd1: out_byte = (idx_q == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
					2'd2: begin
						case (idx_q)
							2'd0: out_byte = {4'b1110, cp[15:12]};
							2'd1: out_byte = {2'b10, cp[11:6]};
							default: out_byte = {2'b10, cp[5:0]};
						endcase
					end
					default: begin
						case (idx_q)
							2'd0: out_byte = {5'b11110, cp[20:18]};
							2'd1: out_byte = {2'b10, cp[17:12]};
							2'd2: out_byte = {2'b10, cp[11:6]};
							default: out_byte = {2'b10, cp[5:0]};
						endcase
					end
				endcase
			end
			default: out_byte = 8'h00;
		endcase
	end

	always_comb begin
		case (cur_q.op)
			OP_DONE: kind = KIND_DONE;
			OP_ERR:  kind = KIND_ERROR;
			default: kind = KIND_DATA;
		endcase
	end

	assign fault_code = (cur_q.op == OP_ERR) ? cur_q.code : ERR_NONE;
	assign last       = (idx_q == lidx);
	assign res_valid  = cur_vld_q;
	assign beat_done  = cur_vld_q && !res_stall;
	assign cmd_done   = beat_done && last;
	assign q_pop      = (!cur_vld_q || cmd_done) && !q_empty;

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= 2'd0;
		end else begin
			if (q_pop) begin
				cur_vld_q <= 1'b1;
				idx_q     <= 2'd0;
			end else if (cmd_done) begin
				cur_vld_q <= 1'b0;
				idx_q     <= 2'd0;
			end else if (beat_done) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

/* test/json_string_unescape_utf8_tb.sv */
// self-checking testbench for the json string unescaper, directed table then random strings
module json_string_unescape_utf8_tb;
	import jsu_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 103;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [7:0] ob;
		res_kind_t  k;
		err_code_t  ec;
		logic       lst;
	} utf8_beat_t;

	typedef struct packed {
		logic [7:0] c;
		logic       chk;
		utf8_beat_t want;
	} text_row_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       text_valid = 1'b0;
	logic       text_stall;
	logic [7:0] text_byte = 8'h00;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic [3:0] fault_code;
	logic       last;

	json_string_unescape_utf8 u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_byte  (text_byte),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_byte   (out_byte),
		.kind       (kind),
		.fault_code (fault_code),
		.last       (last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// decoder copy
	phase_t      ph = PH_WAIT;
	logic [15:0] hex_acc = 16'h0000;
	logic [9:0]  hi_bits = 10'h000;
	logic [1:0]  dcnt = 2'd0;
	logic        bad_hex = 1'b0;

	utf8_beat_t  pending_beats[$];
	int          pred_cnt = 0;
	utf8_beat_t  first_pred;
	logic [7:0]  text_q[$];
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          quiet_cycles = 0;
	int          errors = 0;

	logic [7:0] simple_esc [8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

	localparam utf8_beat_t NO_BEAT = '{8'h00, KIND_DATA, ERR_NONE, 1'b0};

	text_row_t text_rows [27] = '{
		'{8'h00, 1'b1, '{8'h00, KIND_ERROR, ERR_NO_QUOTE, 1'b1}},
		'{8'hFF, 1'b1, '{8'h00, KIND_ERROR, ERR_NO_QUOTE, 1'b1}},
		'{CH_QUOTE, 1'b0, NO_BEAT},
		'{8'hFF, 1'b1, '{8'hFF, KIND_DATA, ERR_NONE, 1'b1}},
		'{CH_SPACE, 1'b1, '{CH_SPACE, KIND_DATA, ERR_NONE, 1'b1}},
		'{8'h1F, 1'b1, '{8'h00, KIND_ERROR, ERR_CTRL_CHAR, 1'b1}},
		'{CH_QUOTE, 1'b0, NO_BEAT},
		'{CH_BSL, 1'b0, NO_BEAT},
		'{CH_NUL, 1'b1, '{8'h00, KIND_ERROR, ERR_UNTERM_ESC, 1'b1}},
		'{CH_QUOTE, 1'b0, NO_BEAT},
		'{CH_BSL, 1'b0, NO_BEAT},
		'{CH_U, 1'b0, NO_BEAT},
		'{8'h41, 1'b0, NO_BEAT},
		'{CH_NUL, 1'b1, '{8'h00, KIND_ERROR, ERR_TRUNC_UNI, 1'b1}},
		'{CH_QUOTE, 1'b0, NO_BEAT},
		'{CH_BSL, 1'b0, NO_BEAT},
		'{8'h61, 1'b1, '{8'h00, KIND_ERROR, ERR_BAD_ESC, 1'b1}},
		'{CH_QUOTE, 1'b0, NO_BEAT},
		'{CH_NUL, 1'b1, '{8'h00, KIND_ERROR, ERR_UNTERM_STR, 1'b1}},
		'{CH_QUOTE, 1'b0, NO_BEAT},
		'{CH_BSL, 1'b0, NO_BEAT},
		'{CH_U, 1'b0, NO_BEAT},
		'{8'h30, 1'b0, NO_BEAT},
		'{8'h30, 1'b0, NO_BEAT},
		'{8'h30, 1'b0, NO_BEAT},
		'{8'h30, 1'b1, '{8'h00, KIND_DATA, ERR_NONE, 1'b1}},
		'{CH_QUOTE, 1'b1, '{8'h00, KIND_DONE, ERR_NONE, 1'b1}}
	};

	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
		if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
		if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
		return 5'd16;
	endfunction

	task automatic put_beat(input logic [7:0] b, input res_kind_t k, input err_code_t e,
			input logic l);
		utf8_beat_t bt;
		bt = '{b, k, e, l};
		pending_beats.push_back(bt);
		if (pred_cnt == 0) first_pred = bt;
		pred_cnt++;
	endtask

	task automatic fail_with(input err_code_t e);
		put_beat(8'h00, KIND_ERROR, e, 1'b1);
		ph = PH_WAIT;
	endtask

	task automatic put_code_point(input logic [CP_W-1:0] cp);
		if (cp <= 21'h7F) begin
			put_beat(cp[7:0], KIND_DATA, ERR_NONE, 1'b1);
		end else if (cp <= 21'h7FF) begin
			put_beat(8'hC0 | cp[10:6], KIND_DATA, ERR_NONE, 1'b0);
			put_beat(8'h80 | cp[5:0], KIND_DATA, ERR_NONE, 1'b1);
		end else if (cp <= 21'hFFFF) begin
			put_beat(8'hE0 | cp[15:12], KIND_DATA, ERR_NONE, 1'b0);
			put_beat(8'h80 | cp[11:6], KIND_DATA, ERR_NONE, 1'b0);
			put_beat(8'h80 | cp[5:0], KIND_DATA, ERR_NONE, 1'b1);
		end else begin
			put_beat(8'hF0 | cp[20:18], KIND_DATA, ERR_NONE, 1'b0);
			put_beat(8'h80 | cp[17:12], KIND_DATA, ERR_NONE, 1'b0);
			put_beat(8'h80 | cp[11:6], KIND_DATA, ERR_NONE, 1'b0);
			put_beat(8'h80 | cp[5:0], KIND_DATA, ERR_NONE, 1'b1);
		end
	endtask

	task automatic start_hex(input phase_t nxt);
		ph = nxt;
		hex_acc = 16'h0000;
		dcnt = 2'd0;
		bad_hex = 1'b0;
	endtask

	task automatic take_digit(input logic [7:0] c, output logic full);
		logic [4:0] d;
		d = nibble_of(c);
		if (d[4]) begin
			bad_hex = 1'b1;
			d = 5'd0;
		end
		hex_acc = {hex_acc[11:0], d[3:0]};
		full = (dcnt == 2'd3);
		dcnt = dcnt + 2'd1;
	endtask

	task automatic unescape_byte(input logic [7:0] c);
		logic full;
		pred_cnt = 0;
		case (ph)
			PH_WAIT: begin
				if (c == CH_QUOTE) ph = PH_STR;
				else fail_with(ERR_NO_QUOTE);
			end
			PH_STR: begin
				if (c == CH_NUL) begin
					fail_with(ERR_UNTERM_STR);
				end else if (c == CH_QUOTE) begin
					ph = PH_WAIT;
					put_beat(8'h00, KIND_DONE, ERR_NONE, 1'b1);
				end else if (c == CH_BSL) begin
					ph = PH_ESC;
				end else if (c < CH_SPACE) begin
					fail_with(ERR_CTRL_CHAR);
				end else begin
					put_beat(c, KIND_DATA, ERR_NONE, 1'b1);
				end
			end
			PH_ESC: begin
				if (c == CH_NUL) begin
					fail_with(ERR_UNTERM_ESC);
				end else begin
					ph = PH_STR;
					case (c)
						CH_QUOTE, CH_BSL, CH_SLASH: put_beat(c, KIND_DATA, ERR_NONE, 1'b1);
						CH_B: put_beat(8'h08, KIND_DATA, ERR_NONE, 1'b1);
						CH_F: put_beat(8'h0C, KIND_DATA, ERR_NONE, 1'b1);
						CH_N: put_beat(8'h0A, KIND_DATA, ERR_NONE, 1'b1);
						CH_R: put_beat(8'h0D, KIND_DATA, ERR_NONE, 1'b1);
						CH_T: put_beat(8'h09, KIND_DATA, ERR_NONE, 1'b1);
						CH_U: start_hex(PH_HEX);
						default: fail_with(ERR_BAD_ESC);
					endcase
				end
			end
			PH_HEX: begin
				if (c == CH_NUL) begin
					fail_with(ERR_TRUNC_UNI);
				end else begin
					take_digit(c, full);
					if (full) begin
						if (bad_hex) begin
							fail_with(ERR_BAD_HEX);
						end else if (hex_acc[15:10] == HI_SURR_TAG) begin
							hi_bits = hex_acc[9:0];
							ph = PH_LOW_BS;
						end else if (hex_acc[15:10] == LO_SURR_TAG) begin
							fail_with(ERR_STRAY_LOW);
						end else begin
							ph = PH_STR;
							put_code_point({5'd0, hex_acc});
						end
					end
				end
			end
			PH_LOW_BS: begin
				if (c != CH_BSL) fail_with(ERR_MISSING_LOW);
				else ph = PH_LOW_U;
			end
			PH_LOW_U: begin
				if (c != CH_U) fail_with(ERR_MISSING_LOW);
				else start_hex(PH_LOW_HEX);
			end
			PH_LOW_HEX: begin
				if (c == CH_NUL) begin
					fail_with(ERR_TRUNC_LOW);
				end else begin
					take_digit(c, full);
					if (full) begin
						if (bad_hex) begin
							fail_with(ERR_BAD_LOW_HEX);
						end else if (hex_acc[15:10] != LO_SURR_TAG) begin
							fail_with(ERR_LOW_RANGE);
						end else begin
							ph = PH_STR;
							put_code_point(SUPP_BASE + {1'b0, hi_bits, hex_acc[9:0]});
						end
					end
				end
			end
			default: begin
				fail_with(ERR_NO_QUOTE);
			end
		endcase
	endtask

	task automatic check_beat();
		utf8_beat_t w;
		if (pending_beats.size() == 0) begin
			$error("result beat with nothing expected: out_byte %h kind %0d fault_code %0d",
				out_byte, kind, fault_code);
			errors++;
		end else begin
			w = pending_beats.pop_front();
			if (out_byte !== w.ob) begin
				$error("out_byte: expected %h, got %h", w.ob, out_byte);
				errors++;
			end
			if (kind !== w.k) begin
				$error("kind: expected %0d, got %0d", w.k, kind);
				errors++;
			end
			if (fault_code !== w.ec) begin
				$error("fault_code: expected %0d, got %0d", w.ec, fault_code);
				errors++;
			end
			if (last !== w.lst) begin
				$error("last: expected %0d, got %0d", w.lst, last);
				errors++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (text_valid && !text_stall) unescape_byte(text_byte);
			if (res_valid && !res_stall) check_beat();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_valid && !text_stall) || (res_valid && !res_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	always @(negedge clk) begin
		res_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// stimulus generation
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + n;
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10;
	endfunction

	function automatic logic [7:0] bad_digit();
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255)); while (nibble_of(c) < 5'd16);
		return c;
	endfunction

	function automatic logic [9:0] surr_bits();
		case ($urandom_range(0, 3))
			0: return 10'h000;
			1: return 10'h3FF;
			default: return 10'($urandom_range(0, 1023));
		endcase
	endfunction

	task automatic push_digits(input logic [15:0] v, input int n, input int bad_at);
		for (int i = 0; i < n; i++)
			text_q.push_back(i == bad_at ? bad_digit() : hex_char(v[15 - 4 * i -: 4]));
	endtask

	task automatic open_u();
		text_q.push_back(CH_BSL);
		text_q.push_back(CH_U);
	endtask

	task automatic push_high();
		open_u();
		push_digits({HI_SURR_TAG, surr_bits()}, 4, -1);
	endtask

	task automatic add_good_token();
		logic [7:0]  c;
		logic [15:0] v;
		case ($urandom_range(0, 4))
			0, 1: begin
				do c = 8'($urandom_range(32, 255)); while (c == CH_QUOTE || c == CH_BSL);
				text_q.push_back(c);
			end
			2: begin
				text_q.push_back(CH_BSL);
				text_q.push_back(simple_esc[$urandom_range(0, 7)]);
			end
			3: begin
				case ($urandom_range(0, 4))
					0: v = 16'($urandom_range(0, 16'h7F));
					1: v = 16'($urandom_range(16'h80, 16'h7FF));
					2: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0800;
					default: do v = 16'($urandom_range(16'h800, 16'hFFFF));
						while (v[15:11] == 5'b11011);
				endcase
				open_u();
				push_digits(v, 4, -1);
			end
			default: begin
				push_high();
				open_u();
				push_digits({LO_SURR_TAG, surr_bits()}, 4, -1);
			end
		endcase
	endtask

	task automatic add_broken_token();
		logic [7:0]  c;
		logic [15:0] v;
		int          k;
		case ($urandom_range(0, 10))
			0: text_q.push_back(8'($urandom_range(1, 31)));
			1: text_q.push_back(CH_NUL);
			2: begin
				text_q.push_back(CH_BSL);
				text_q.push_back(CH_NUL);
			end
			3: begin
				do begin
					c = 8'($urandom_range(1, 255));
					k = (c == CH_U) ? 1 : 0;
					foreach (simple_esc[j]) if (c == simple_esc[j]) k = 1;
				end while (k != 0);
				text_q.push_back(CH_BSL);
				text_q.push_back(c);
			end
			4: begin
				open_u();
				k = $urandom_range(0, 3);
				push_digits(16'($urandom), k,
					(k > 0 && $urandom_range(0, 2) == 0) ? int'($urandom_range(0, k - 1)) : -1);
				text_q.push_back(CH_NUL);
			end
			5: begin
				open_u();
				push_digits(16'($urandom), 4, $urandom_range(0, 3));
			end
			6: begin
				push_high();
				case ($urandom_range(0, 2))
					0: begin
						do c = 8'($urandom_range(0, 255)); while (c == CH_BSL);
						text_q.push_back(c);
					end
					1: begin
						text_q.push_back(CH_BSL);
						do c = 8'($urandom_range(0, 255)); while (c == CH_U);
						text_q.push_back(c);
					end
					default: text_q.push_back(CH_NUL);
				endcase
			end
			7: begin
				push_high();
				open_u();
				k = $urandom_range(0, 3);
				push_digits({LO_SURR_TAG, surr_bits()}, k, -1);
				text_q.push_back(CH_NUL);
			end
			8: begin
				push_high();
				open_u();
				push_digits({LO_SURR_TAG, surr_bits()}, 4, $urandom_range(0, 3));
			end
			9: begin
				push_high();
				open_u();
				do v = 16'($urandom); while (v[15:10] == LO_SURR_TAG);
				push_digits(v, 4, -1);
			end
			default: begin
				open_u();
				push_digits({LO_SURR_TAG, surr_bits()}, 4, -1);
			end
		endcase
	endtask

	task automatic make_string();
		int n;
		if ($urandom_range(0, 9) == 0) text_q.push_back(8'($urandom_range(0, 255)));
		text_q.push_back(CH_QUOTE);
		n = $urandom_range(0, 3);
		repeat (n) add_good_token();
		if ($urandom_range(0, 1)) add_broken_token();
		else text_q.push_back(CH_QUOTE);
	endtask

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_byte(input logic [7:0] c);
		while ($urandom_range(0, 99) < idle_pct) begin
			text_valid <= 1'b0;
			@(negedge clk);
		end
		text_valid <= 1'b1;
		text_byte <= c;
		@(posedge clk);
		while (text_stall) @(posedge clk);
		@(negedge clk);
	endtask

	int idle_tbl [4] = '{0, 85, 0, 28};
	int stall_tbl [4] = '{0, 0, 85, 28};

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (text_rows[r]) begin
			send_byte(text_rows[r].c);
			if (text_rows[r].chk && (pred_cnt == 0 || first_pred != text_rows[r].want)) begin
				$error("directed row %0d: table beat %h, decoder gives %h",
					r, text_rows[r].want, first_pred);
				errors++;
			end
		end

		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_tbl[p];
			stall_pct = stall_tbl[p];
			while (text_q.size() < PHASE_ITEMS) make_string();
			while (text_q.size() != 0) send_byte(text_q.pop_front());
		end
		text_valid <= 1'b0;

		while (pending_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && pending_beats.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* files.f */
sv/jsu_pkg.sv
sv/jsu_front.sv
sv/jsu_queue.sv
sv/jsu_back.sv
sv/json_string_unescape_utf8.sv
test/json_string_unescape_utf8_tb.sv
